// File: rtl/ipv4fte_pkg.sv
// shared types and constants of the ipv4 five-tuple extractor
package ipv4fte_pkg;

  // header field values
  localparam logic [15:0] EthPIp     = 16'h0800;
  localparam logic [7:0]  IpprotoTcp = 8'd6;
  localparam logic [7:0]  IpprotoUdp = 8'd17;

  // byte offset counter
  localparam int unsigned CountW = 6;
  localparam logic [CountW-1:0] CountMax = '1;

  // header byte offsets
  localparam logic [CountW-1:0] OffEtypeHi = 6'd12;
  localparam logic [CountW-1:0] OffEtypeLo = 6'd13;
  localparam logic [CountW-1:0] OffProto   = 6'd23;
  localparam logic [CountW-1:0] OffSrcIp   = 6'd26;
  localparam logic [CountW-1:0] OffSrcIpE  = 6'd29;
  localparam logic [CountW-1:0] OffDstIp   = 6'd30;
  localparam logic [CountW-1:0] OffDstIpE  = 6'd33;
  localparam logic [CountW-1:0] OffSport   = 6'd34;
  localparam logic [CountW-1:0] OffSportE  = 6'd35;
  localparam logic [CountW-1:0] OffDport   = 6'd36;
  localparam logic [CountW-1:0] OffDportE  = 6'd37;
  localparam logic [CountW-1:0] OffFlags   = 6'd47;

  // last-byte offsets below which a header is truncated (length minus one)
  localparam logic [CountW-1:0] MinEthPos = 6'd13;
  localparam logic [CountW-1:0] MinIpPos  = 6'd33;
  localparam logic [CountW-1:0] MinUdpPos = 6'd41;
  localparam logic [CountW-1:0] MinTcpPos = 6'd53;

  // queue between front and back
  localparam int unsigned QDepth = 2;
  localparam int unsigned QAw    = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  // one finished verdict word
  typedef struct packed {
    logic        verdict;
    logic        event_valid;
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
    logic [15:0] src_l4;
    logic [15:0] dst_l4;
    logic [7:0]  protocol;
    logic        flow_direction;
    logic [7:0]  tcp_ctrl;
  } result_t;

endpackage

// File: rtl/ipv4fte_front.sv
// front end: byte offset counter, header capture and frame classification
module ipv4fte_front (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   accept_i,
  input  logic [7:0]             data_byte_i,
  input  logic                   last_byte_i,
  input  logic                   direction_i,
  output logic                   push_o,
  output ipv4fte_pkg::result_t   rec_o
);

  logic [ipv4fte_pkg::CountW-1:0] count_q, count_d;
  logic [15:0] etype_q, etype_d;
  logic [7:0]  proto_q, proto_d;
  logic [31:0] src_q, src_d;
  logic [31:0] dst_q, dst_d;
  logic [15:0] sport_q, sport_d;
  logic [15:0] dport_q, dport_d;
  logic [7:0]  flags_q, flags_d;
  logic        dir_q, dir_d;
  logic [ipv4fte_pkg::CountW-1:0] pos;

  assign pos = count_q;

  // capture header bytes by offset
  always_comb begin
    etype_d = etype_q;
    proto_d = proto_q;
    src_d   = src_q;
    dst_d   = dst_q;
    sport_d = sport_q;
    dport_d = dport_q;
    flags_d = flags_q;
    dir_d   = dir_q;
    if (accept_i) begin
      if (pos == '0) begin
        dir_d = direction_i;
      end
      if (pos == ipv4fte_pkg::OffEtypeHi || pos == ipv4fte_pkg::OffEtypeLo) begin
        etype_d = {etype_q[7:0], data_byte_i};
      end else if (pos == ipv4fte_pkg::OffProto) begin
        proto_d = data_byte_i;
      end else if (pos >= ipv4fte_pkg::OffSrcIp && pos <= ipv4fte_pkg::OffSrcIpE) begin
        src_d = {src_q[23:0], data_byte_i};
      end else if (pos >= ipv4fte_pkg::OffDstIp && pos <= ipv4fte_pkg::OffDstIpE) begin
        dst_d = {dst_q[23:0], data_byte_i};
      end else if (pos == ipv4fte_pkg::OffSport || pos == ipv4fte_pkg::OffSportE) begin
        sport_d = {sport_q[7:0], data_byte_i};
      end else if (pos == ipv4fte_pkg::OffDport || pos == ipv4fte_pkg::OffDportE) begin
        dport_d = {dport_q[7:0], data_byte_i};
      end else if (pos == ipv4fte_pkg::OffFlags) begin
        flags_d = data_byte_i;
      end
    end
  end

  // saturating offset counter, cleared after the last byte
  always_comb begin
    count_d = count_q;
    if (accept_i) begin
      if (last_byte_i) begin
        count_d = '0;
      end else if (count_q != ipv4fte_pkg::CountMax) begin
        count_d = count_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      etype_q <= '0;
      proto_q <= '0;
      src_q   <= '0;
      dst_q   <= '0;
      sport_q <= '0;
      dport_q <= '0;
      flags_q <= '0;
      dir_q   <= 1'b0;
    end else begin
      etype_q <= etype_d;
      proto_q <= proto_d;
      src_q   <= src_d;
      dst_q   <= dst_d;
      sport_q <= sport_d;
      dport_q <= dport_d;
      flags_q <= flags_d;
      dir_q   <= dir_d;
    end
  end

  // verdict on the last byte, from the values including that byte
  always_comb begin
    rec_o = '0;
    if (pos < ipv4fte_pkg::MinEthPos) begin
      rec_o.verdict = 1'b1;
    end else if (etype_d != ipv4fte_pkg::EthPIp) begin
      rec_o.verdict = 1'b0;
    end else if (pos < ipv4fte_pkg::MinIpPos) begin
      rec_o.verdict = 1'b1;
    end else if (proto_d == ipv4fte_pkg::IpprotoTcp && pos < ipv4fte_pkg::MinTcpPos) begin
      rec_o.verdict = 1'b1;
    end else if (proto_d == ipv4fte_pkg::IpprotoUdp && pos < ipv4fte_pkg::MinUdpPos) begin
      rec_o.verdict = 1'b1;
    end else begin
      rec_o.event_valid    = 1'b1;
      rec_o.src_ip         = src_d;
      rec_o.dst_ip         = dst_d;
      rec_o.protocol       = proto_d;
      rec_o.flow_direction = dir_d;
      if (proto_d == ipv4fte_pkg::IpprotoTcp || proto_d == ipv4fte_pkg::IpprotoUdp) begin
        rec_o.src_l4 = sport_d;
        rec_o.dst_l4 = dport_d;
      end
      if (proto_d == ipv4fte_pkg::IpprotoTcp) begin
        rec_o.tcp_ctrl = flags_d;
      end
    end
  end

  assign push_o = accept_i && last_byte_i;

`ifndef NO_ASSERTIONS
  // a middle byte advances the offset unless it is saturated
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && !last_byte_i && count_q != ipv4fte_pkg::CountMax
    |=> count_q == $past(count_q) + 1'b1)
    else $error("offset counter did not advance");

  // a last byte starts the next frame at offset zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && last_byte_i |=> count_q == '0)
    else $error("offset counter not cleared after last byte");
`endif

endmodule

// File: rtl/ipv4fte_queue.sv
// short result queue between the front end and the output stage
module ipv4fte_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  ipv4fte_pkg::result_t push_data_i,
  output logic                 full_o,
  input  logic                 pop_i,
  output logic                 nonempty_o,
  output ipv4fte_pkg::result_t head_o
);

  ipv4fte_pkg::result_t mem_q [ipv4fte_pkg::QDepth];
  logic [ipv4fte_pkg::QAw-1:0]   wr_q, wr_d;
  logic [ipv4fte_pkg::QAw-1:0]   rd_q, rd_d;
  logic [ipv4fte_pkg::QCntW-1:0] cnt_q, cnt_d;

  assign full_o     = (cnt_q == ipv4fte_pkg::QCntW'(ipv4fte_pkg::QDepth));
  assign nonempty_o = (cnt_q != '0);
  assign head_o     = mem_q[rd_q];

  // pointer and fill count update
  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == ipv4fte_pkg::QAw'(ipv4fte_pkg::QDepth - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop_i) begin
      rd_d = (rd_q == ipv4fte_pkg::QAw'(ipv4fte_pkg::QDepth - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // storage write
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

`ifndef NO_ASSERTIONS
  // never written while full
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(push_i && full_o))
    else $error("queue overflow");

  // never read while empty
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(pop_i && !nonempty_o))
    else $error("queue underflow");
`endif

endmodule

// File: rtl/ipv4fte_back.sv
// back end: output register that drains the queue toward the consumer
module ipv4fte_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 q_nonempty_i,
  input  ipv4fte_pkg::result_t q_head_i,
  output logic                 q_pop_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output ipv4fte_pkg::result_t out_rec_o
);

  logic                 vld_q, vld_d;
  ipv4fte_pkg::result_t rec_q;

  // load a new word when the register is free or being taken
  assign q_pop_o = q_nonempty_i && (!vld_q || out_ready_i);

  always_comb begin
    vld_d = vld_q;
    if (q_pop_o) begin
      vld_d = 1'b1;
    end else if (out_ready_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      rec_q <= q_head_i;
    end
  end

  assign out_valid_o = vld_q;
  assign out_rec_o   = rec_q;

`ifndef NO_ASSERTIONS
  // a reported flow event always passes the frame
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q && rec_q.event_valid |-> !rec_q.verdict)
    else $error("event on a dropped frame");
`endif

endmodule

// File: rtl/ipv4_five_tuple_extractor.sv
// top level of the ethernet/ipv4 five-tuple extractor
// Takes one frame byte per cycle on the input channel while input ready is high, and gives
// one verdict word per frame, which passes through the queue and the output register. Each
// byte is only an offset compare and a capture in the front end. Verdict words wait in a
// two-entry queue and an output register, so the input keeps taking bytes while a word
// waits to be taken; input ready falls only when the queue is full. The IPv4 header
// is taken as 20 bytes (IHL is not checked) and the byte offset saturates at 63.
module ipv4_five_tuple_extractor (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        last_byte_i,
  input  logic        direction_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        verdict_o,
  output logic        event_valid_o,
  output logic [31:0] src_ip_o,
  output logic [31:0] dst_ip_o,
  output logic [15:0] src_l4_o,
  output logic [15:0] dst_l4_o,
  output logic [7:0]  protocol_o,
  output logic        flow_direction_o,
  output logic [7:0]  tcp_ctrl_o
);

  logic                 accept;
  logic                 push;
  logic                 full;
  logic                 pop;
  logic                 nonempty;
  ipv4fte_pkg::result_t front_rec;
  ipv4fte_pkg::result_t head_rec;
  ipv4fte_pkg::result_t out_rec;

  assign in_ready_o = !full;
  assign accept     = in_valid_i && in_ready_o;

  // byte classification
  ipv4fte_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .data_byte_i (data_byte_i),
    .last_byte_i (last_byte_i),
    .direction_i (direction_i),
    .push_o      (push),
    .rec_o       (front_rec)
  );

  // verdict word queue
  ipv4fte_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (front_rec),
    .full_o      (full),
    .pop_i       (pop),
    .nonempty_o  (nonempty),
    .head_o      (head_rec)
  );

  // output stage
  ipv4fte_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_nonempty_i (nonempty),
    .q_head_i     (head_rec),
    .q_pop_o      (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_rec_o    (out_rec)
  );

  assign verdict_o        = out_rec.verdict;
  assign event_valid_o    = out_rec.event_valid;
  assign src_ip_o         = out_rec.src_ip;
  assign dst_ip_o         = out_rec.dst_ip;
  assign src_l4_o         = out_rec.src_l4;
  assign dst_l4_o         = out_rec.dst_l4;
  assign protocol_o       = out_rec.protocol;
  assign flow_direction_o = out_rec.flow_direction;
  assign tcp_ctrl_o       = out_rec.tcp_ctrl;

endmodule
